// ----- sv/otwk_pkg.sv -----
// otwk_pkg: shared types, widths and constants of the three-wheel kinematics pipeline
// no dependencies; imported by every module of the block
package otwk_pkg;

  // field widths
  localparam int SPEED_W   = 15;
  localparam int HEADING_W = 16;
  localparam int ROT_W     = 4;
  localparam int RPM_W     = 16;
  localparam int DB_W      = 12;
  localparam int GAIN_W    = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_GAIN = 1'd1;
  localparam int CFG_DATA_W = 16;

  // angle and cordic
  localparam int TURN_BITS      = 24;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 24;
  localparam int XY_W           = 34;
  localparam int Z_W            = 26;
  localparam int ATAN_W         = 22;
  localparam logic signed [XY_W-1:0] CORDIC_START = 34'sd652032874;

  // q1.15 trig results
  localparam int Q_W    = 16;
  localparam int Q_FRAC = 15;

  // mixing
  localparam int WHEELS    = 3;
  localparam int COMP_W    = 31;
  localparam int SUM_W     = 47;
  localparam int ROT_SHIFT = 27;
  localparam logic signed [15:0] COEF_A = 16'sd19005;
  localparam logic signed [15:0] COEF_B = 16'sd10813;
  localparam logic signed [15:0] COEF_C = 16'sd21955;

  // gain scaling
  localparam int MAG_W     = 46;
  localparam int SPLIT     = 23;
  localparam int PP_W      = 39;
  localparam int TOT_W     = 62;
  localparam int RPM_SHIFT = 48;
  localparam int RHI_W     = TOT_W - RPM_SHIFT;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic [HEADING_W-1:0]      heading;
    logic signed [ROT_W-1:0]   rotation;
  } cmd_t;

  typedef struct packed {
    logic signed [RPM_W-1:0] wheel_one_rpm;
    logic signed [RPM_W-1:0] wheel_two_rpm;
    logic signed [RPM_W-1:0] wheel_three_rpm;
  } wheel_t;

  // sideband carried alongside the cordic rotation
  typedef struct packed {
    logic                      flip;
    logic signed [SPEED_W-1:0] speed;
    logic signed [ROT_W-1:0]   rotation;
  } side_t;

  typedef logic signed [SUM_W-1:0] wsum_t;
  typedef logic signed [RPM_W-1:0] rpm_t;

  // arctangent of 2^-i in 2^-24 turn
  function automatic logic [ATAN_W-1:0] atan_turn(input int unsigned i);
    logic [ATAN_W-1:0] a;
    case (i)
      0:       a = 22'd2097152;
      1:       a = 22'd1238021;
      2:       a = 22'd654136;
      3:       a = 22'd332050;
      4:       a = 22'd166669;
      5:       a = 22'd83416;
      6:       a = 22'd41718;
      7:       a = 22'd20860;
      8:       a = 22'd10430;
      9:       a = 22'd5215;
      10:      a = 22'd2608;
      11:      a = 22'd1304;
      12:      a = 22'd652;
      13:      a = 22'd326;
      14:      a = 22'd163;
      15:      a = 22'd81;
      16:      a = 22'd41;
      17:      a = 22'd20;
      18:      a = 22'd10;
      19:      a = 22'd5;
      20:      a = 22'd3;
      21:      a = 22'd1;
      22:      a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- sv/otwk_cordic.sv -----
// otwk_cordic: pipelined cordic, one rotation step per stage, then q1.15 rounding
// depends on otwk_pkg
module otwk_cordic import otwk_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  cmd_t                      cmd,
  output logic                      valid,
  output logic signed [Q_W-1:0]     cos_q,
  output logic signed [Q_W-1:0]     sin_q,
  output logic signed [SPEED_W-1:0] speed,
  output logic signed [ROT_W-1:0]   rotation
);

  localparam logic [TURN_BITS-1:0] ANGLE_MASK =
    {TURN_BITS{1'b1}} << (TURN_BITS - ANGLE_BITS);

  logic [TURN_BITS-1:0] angle;
  logic                 flip_in;
  logic signed [Z_W-1:0] z_in;

  logic [CORDIC_STEPS:0]  v;
  logic signed [XY_W-1:0] x  [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y  [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z  [CORDIC_STEPS+1];
  side_t                  sd [CORDIC_STEPS+1];

  // quadrants two and three are folded by a half turn, negating both results
  always_comb begin
    angle   = {cmd.heading, {(TURN_BITS-HEADING_W){1'b0}}} & ANGLE_MASK;
    flip_in = angle[TURN_BITS-1] ^ angle[TURN_BITS-2];
    z_in    = Z_W'($signed({angle[TURN_BITS-1] ^ flip_in, angle[TURN_BITS-2:0]}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]  <= CORDIC_START;
      y[0]  <= '0;
      z[0]  <= z_in;
      sd[0] <= '{flip: flip_in, speed: cmd.speed, rotation: cmd.rotation};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  at;
    logic                   up;

    always_comb begin
      dx = y[i] >>> i;
      dy = x[i] >>> i;
      at = $signed({{(Z_W-ATAN_W){1'b0}}, atan_turn(i)});
      up = ~z[i][Z_W-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[i+1]  <= up ? x[i] - dx : x[i] + dx;
        y[i+1]  <= up ? y[i] + dy : y[i] - dy;
        z[i+1]  <= up ? z[i] - at : z[i] + at;
        sd[i+1] <= sd[i];
      end
    end
  end

  // rounding, first stage: sign and magnitude
  logic [XY_W-1:0] mx;
  logic [XY_W-1:0] my;
  logic            nx;
  logic            ny;
  logic            v_mag;
  side_t           sd_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mag <= 1'b0;
    end else if (en) begin
      v_mag <= v[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx     <= x[CORDIC_STEPS][XY_W-1] ? XY_W'(-x[CORDIC_STEPS]) : XY_W'(x[CORDIC_STEPS]);
      my     <= y[CORDIC_STEPS][XY_W-1] ? XY_W'(-y[CORDIC_STEPS]) : XY_W'(y[CORDIC_STEPS]);
      nx     <= x[CORDIC_STEPS][XY_W-1] ^ sd[CORDIC_STEPS].flip;
      ny     <= y[CORDIC_STEPS][XY_W-1] ^ sd[CORDIC_STEPS].flip;
      sd_mag <= sd[CORDIC_STEPS];
    end
  end

  // rounding, second stage: half away from zero, clamp, restore sign
  function automatic logic signed [Q_W-1:0] round_q15(input logic [XY_W-1:0] m,
                                                       input logic neg);
    logic [XY_W:0]    sum;
    logic [XY_W:0]    r;
    logic [Q_W-1:0]   sat;
    sum = {1'b0, m} + (XY_W+1)'(1 << (Q_FRAC-1));
    r   = sum >> Q_FRAC;
    sat = (r > (XY_W+1)'(2**(Q_W-1) - 1)) ? Q_W'(2**(Q_W-1) - 1) : r[Q_W-1:0];
    return neg ? $signed(-sat) : $signed(sat);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q    <= round_q15(mx, nx);
      sin_q    <= round_q15(my, ny);
      speed    <= sd_mag.speed;
      rotation <= sd_mag.rotation;
    end
  end

endmodule

// ----- sv/otwk_mix.sv -----
// otwk_mix: velocity components, deadband and the fixed 3x3 wheel mixing matrix
// depends on otwk_pkg
module otwk_mix import otwk_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [Q_W-1:0]     cos_q,
  input  logic signed [Q_W-1:0]     sin_q,
  input  logic signed [SPEED_W-1:0] speed,
  input  logic signed [ROT_W-1:0]   rotation,
  input  logic [DB_W-1:0]           deadband,
  output logic                      valid,
  output wsum_t                     wsum [WHEELS]
);

  logic [2:0] v;

  // stage 1: components
  logic signed [COMP_W-1:0] x1;
  logic signed [COMP_W-1:0] y1;
  logic signed [ROT_W-1:0]  r1;
  // stage 2: deadband
  logic signed [COMP_W-1:0] x2;
  logic signed [COMP_W-1:0] y2;
  logic signed [ROT_W-1:0]  r2;
  logic signed [COMP_W-1:0] lim;
  // stage 3: coefficient products
  wsum_t pa;
  wsum_t pb;
  wsum_t pc;
  wsum_t pw;

  assign lim = $signed({{(COMP_W-DB_W-Q_FRAC){1'b0}}, deadband, {Q_FRAC{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      valid <= 1'b0;
    end else if (en) begin
      v     <= {v[1:0], in_valid};
      valid <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= COMP_W'(speed) * COMP_W'(cos_q);
      y1 <= COMP_W'(speed) * COMP_W'(sin_q);
      r1 <= rotation;

      x2 <= (x1 < lim && x1 > -lim) ? '0 : x1;
      y2 <= (y1 < lim && y1 > -lim) ? '0 : y1;
      r2 <= r1;

      pa <= SUM_W'(x2) * SUM_W'(COEF_A);
      pb <= SUM_W'(y2) * SUM_W'(COEF_B);
      pc <= SUM_W'(y2) * SUM_W'(COEF_C);
      pw <= (SUM_W'(r2) * SUM_W'(COEF_B)) <<< ROT_SHIFT;

      wsum[0] <= pa - pb + pw;
      wsum[1] <= -pa - pb + pw;
      wsum[2] <= pc + pw;
    end
  end

endmodule

// ----- sv/otwk_scale.sv -----
// otwk_scale: rpm gain shared by all wheels, split multiply, truncation toward zero and saturation
// depends on otwk_pkg
module otwk_scale import otwk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  wsum_t             wsum [WHEELS],
  input  logic [GAIN_W-1:0] rpm_gain,
  output logic              valid,
  output rpm_t              rpm [WHEELS]
);

  logic [2:0] v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v     <= '0;
      valid <= 1'b0;
    end else if (en) begin
      v     <= {v[1:0], in_valid};
      valid <= v[2];
    end
  end

  for (genvar w = 0; w < WHEELS; w++) begin : g_wheel
    logic [MAG_W-1:0] mag;
    logic             n1;
    logic [PP_W-1:0]  ph;
    logic [PP_W-1:0]  pl;
    logic             n2;
    logic [TOT_W-1:0] tot;
    logic [RHI_W-1:0] rhi;
    logic             n3;
    logic [RPM_W:0]   rext;

    assign tot  = (TOT_W'(ph) << SPLIT) + TOT_W'(pl);
    assign rext = (RPM_W+1)'(rhi);

    always_ff @(posedge clk) begin
      if (en) begin
        // sign and magnitude
        n1  <= wsum[w][SUM_W-1];
        mag <= wsum[w][SUM_W-1] ? MAG_W'(-wsum[w]) : MAG_W'(wsum[w]);
        // partial products, high and low halves of the magnitude
        ph  <= PP_W'(mag[MAG_W-1:SPLIT]) * PP_W'(rpm_gain);
        pl  <= PP_W'(mag[SPLIT-1:0]) * PP_W'(rpm_gain);
        n2  <= n1;
        // recombine and drop the fraction
        rhi <= tot[TOT_W-1:RPM_SHIFT];
        n3  <= n2;
        // saturate and restore sign
        if (n3) begin
          rpm[w] <= (rext > (RPM_W+1)'(2**(RPM_W-1))) ? rpm_t'(-(2**(RPM_W-1)))
                                                       : rpm_t'(-rext);
        end else begin
          rpm[w] <= (rext > (RPM_W+1)'(2**(RPM_W-1) - 1)) ? rpm_t'(2**(RPM_W-1) - 1)
                                                           : rpm_t'(rext);
        end
      end
    end
  end

endmodule

// ----- sv/omni_three_wheel_kinematics.sv -----
// omni_three_wheel_kinematics: top level of the three-wheel inverse kinematics pipeline
// depends on otwk_pkg, otwk_cordic, otwk_mix, otwk_scale
//
//   channel  direction  handshake            beat
//   cmd      in         cmd_valid/cmd_stall  cmd_t: speed, heading, rotation
//   wheel    out        wheel_valid/stall    wheel_t: three wheel speeds in rpm
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one command beat per cycle while cmd_stall is low; registered stages: the cordic (angle fold,
// 24 rotation steps, two rounding stages), then mixing, then gain scaling
// the whole pipeline advances on one enable, held only while a result beat
// waits at the output with wheel_stall high; bubbles move along with valid bits
// rst (synchronous) clears every valid bit and loads the register reset values
// cfg_ready is always high; a write lands at the next edge
module omni_three_wheel_kinematics import otwk_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // command beats
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  // wheel speed beats
  output logic                  wheel_valid,
  input  logic                  wheel_stall,
  output wheel_t                wheel,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [DB_W-1:0]   deadband;
  logic [GAIN_W-1:0] rpm_gain;

  // pipeline enable: everything moves unless the output beat is held
  logic en;

  // cordic to mixing
  logic                      c_valid;
  logic signed [Q_W-1:0]     c_cos;
  logic signed [Q_W-1:0]     c_sin;
  logic signed [SPEED_W-1:0] c_speed;
  logic signed [ROT_W-1:0]   c_rot;

  // mixing to scaling
  logic  m_valid;
  wsum_t m_sum [WHEELS];

  // scaling to the port
  rpm_t s_rpm [WHEELS];

  assign cfg_ready = 1'b1;
  assign en        = ~(wheel_valid & wheel_stall);
  assign cmd_stall = ~en;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= DB_W'(205);
      rpm_gain <= GAIN_W'(12223);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEADBAND: deadband <= cfg_data[DB_W-1:0];
        REG_RPM_GAIN: rpm_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sine and cosine of the heading at q1.15
  otwk_cordic #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (cmd_valid),
    .cmd      (cmd),
    .valid    (c_valid),
    .cos_q    (c_cos),
    .sin_q    (c_sin),
    .speed    (c_speed),
    .rotation (c_rot)
  );

  // x and y components, deadband, matrix mix to three wheel sums
  otwk_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_valid),
    .cos_q    (c_cos),
    .sin_q    (c_sin),
    .speed    (c_speed),
    .rotation (c_rot),
    .deadband (deadband),
    .valid    (m_valid),
    .wsum     (m_sum)
  );

  // rpm gain, truncation and saturation; its last stage is the output register
  otwk_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .wsum     (m_sum),
    .rpm_gain (rpm_gain),
    .valid    (wheel_valid),
    .rpm      (s_rpm)
  );

  assign wheel.wheel_one_rpm   = s_rpm[0];
  assign wheel.wheel_two_rpm   = s_rpm[1];
  assign wheel.wheel_three_rpm = s_rpm[2];

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !wheel_valid)
    else $error("result beat valid right after reset");

  // the matrix and gain ranges keep every wheel well inside 14 bits
  a_wheel_range: assert property (@(posedge clk) disable iff (rst)
    wheel_valid |-> (wheel.wheel_one_rpm > -16'sd8192 && wheel.wheel_one_rpm < 16'sd8192 &&
                     wheel.wheel_two_rpm > -16'sd8192 && wheel.wheel_two_rpm < 16'sd8192 &&
                     wheel.wheel_three_rpm > -16'sd8192 &&
                     wheel.wheel_three_rpm < 16'sd8192))
    else $error("wheel speed outside reachable range");

  // a deadband write takes effect at the next edge
  a_deadband_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_DEADBAND) |=>
      deadband == $past(cfg_data[DB_W-1:0]))
    else $error("deadband write lost");

endmodule

// ----- tb/tb_omni_three_wheel_kinematics.sv -----
// tb_omni_three_wheel_kinematics: self-checking bench for the three-wheel kinematics pipeline
// predicts wheel rpm per motion command with its own cordic and mixing model and checks every beat
// depends on otwk_pkg and omni_three_wheel_kinematics
module tb_omni_three_wheel_kinematics;
  import otwk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run limits; the pipeline is 35 deep, so a short tail covers anything in flight
  localparam int CYCLE_LIMIT  = 300000;
  localparam int TAIL_CYCLES  = 60;
  localparam int HOLD_CYCLES  = 150;
  localparam int REPORT_LIMIT = 100;

  // mixing coefficients at q1.15 and the cordic starting x value
  localparam longint MIX_A     = 19005;
  localparam longint MIX_B     = 10813;
  localparam longint MIX_C     = 21955;
  localparam longint START_MAG = 652032874;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_t                  cmd = '0;
  logic                  wheel_valid;
  logic                  wheel_stall = 1'b0;
  wheel_t                wheel;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copies of the two registers, as the block holds them
  logic [DB_W-1:0]   deadband_reg = 12'd205;
  logic [GAIN_W-1:0] gain_reg     = 16'd12223;

  // wheel speeds still owed by the block, oldest first
  wheel_t pending_wheels[$];

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  tx_idle_en     = 1'b1;
  bit  rx_idle_en     = 1'b1;
  int  hold_req       = 0;

  // arctangent of 2^-i, in 2^-24 turn
  longint atan_step [CORDIC_STEPS] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };

  omni_three_wheel_kinematics i_dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .wheel_valid (wheel_valid),
    .wheel_stall (wheel_stall),
    .wheel       (wheel),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // round half away from zero from 2^-30 to q1.15, clamped to +-32767
  function automatic longint round_q15(input longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + 16384) >>> 15;
    if (mag > 32767) mag = 32767;
    return (v < 0) ? -mag : mag;
  endfunction

  // cosine and sine of the heading by 24 cordic rotations
  function automatic void heading_trig(input logic [HEADING_W-1:0] hdg,
                                       output longint cos_q, output longint sin_q);
    logic [TURN_BITS-1:0] ang;
    logic                 flip;
    longint               x, y, z, dx, dy;
    // keep only the top ANGLE_BITS of the 24 bit turn fraction
    ang  = {hdg, 8'h00} & ~((24'd1 << (TURN_BITS - ANGLE_BITS_DEF)) - 24'd1);
    // second and third quadrants are folded by half a turn, negating both results
    flip = (ang[23:22] == 2'd1) || (ang[23:22] == 2'd2);
    if (flip) ang = ang - 24'h800000;
    z = longint'($signed(ang));
    x = START_MAG;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      // arithmetic shifts floor toward minus infinity
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step[i];
      end
    end
    cos_q = round_q15(flip ? -x : x);
    sin_q = round_q15(flip ? -y : y);
  endfunction

  // wheel sum at 2^-42 m/s times gain, truncated by magnitude, then saturated
  function automatic rpm_t scale_rpm(input longint sum);
    longint unsigned mag;
    mag = (sum < 0) ? -sum : sum;
    mag = (mag * gain_reg) >> RPM_SHIFT;
    if (sum < 0) return (mag > 32768) ? rpm_t'(-32768) : rpm_t'(-longint'(mag));
    return (mag > 32767) ? rpm_t'(32767) : rpm_t'(mag);
  endfunction

  function automatic wheel_t predict_wheels(input cmd_t c);
    longint spd, rot, cos_q, sin_q, vx, vy, lim, w;
    wheel_t r;
    spd = longint'($signed(c.speed));
    rot = longint'($signed(c.rotation));
    heading_trig(c.heading, cos_q, sin_q);
    vx  = spd * cos_q;
    vy  = spd * sin_q;
    // deadband is compared at the component scale of 2^-27 m/s, strictly below
    lim = longint'(deadband_reg) * 32768;
    if (vx < lim && vx > -lim) vx = 0;
    if (vy < lim && vy > -lim) vy = 0;
    w = rot * (longint'(1) << ROT_SHIFT);
    r.wheel_one_rpm   = scale_rpm(MIX_A * vx - MIX_B * vy + MIX_B * w);
    r.wheel_two_rpm   = scale_rpm(-MIX_A * vx - MIX_B * vy + MIX_B * w);
    r.wheel_three_rpm = scale_rpm(MIX_C * vy + MIX_B * w);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // wheel side: random stall, long hold-off on request, and the checker
  // ---------------------------------------------------------------------------

  int hold_seen  = 0;
  int hold_left  = 0;
  int stall_left = 0;

  task automatic check_wheel(input string name, input rpm_t exp_v, input rpm_t got_v);
    if (got_v !== exp_v) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t %s: expected %0d actual %0d", $realtime, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    wheel_t exp_w;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d wheel beats outstanding", $realtime,
               pending_wheels.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      // a beat moves when valid is high and our stall was low at this edge
      if (!rst && wheel_valid && !wheel_stall) begin
        if (pending_wheels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t unexpected wheel beat: expected none actual %0d %0d %0d",
                     $realtime, wheel.wheel_one_rpm, wheel.wheel_two_rpm,
                     wheel.wheel_three_rpm);
        end else begin
          exp_w = pending_wheels.pop_front();
          check_wheel("wheel_one_rpm", exp_w.wheel_one_rpm, wheel.wheel_one_rpm);
          check_wheel("wheel_two_rpm", exp_w.wheel_two_rpm, wheel.wheel_two_rpm);
          check_wheel("wheel_three_rpm", exp_w.wheel_three_rpm, wheel.wheel_three_rpm);
        end
      end
      // stall for the next cycle: long hold-off first, then random bursts
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        wheel_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        wheel_stall <= 1'b1;
      end else if (rx_idle_en && !rst && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 4);
        wheel_stall <= 1'b1;
      end else begin
        wheel_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // one command beat, with an optional random gap in front of it
  task automatic send_cmd(input cmd_t c);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    pending_wheels.push_back(predict_wheels(c));
  endtask

  function automatic cmd_t mk_cmd(input int spd, input int hdg, input int rot);
    cmd_t c;
    c.speed    = spd[SPEED_W-1:0];
    c.heading  = hdg[HEADING_W-1:0];
    c.rotation = rot[ROT_W-1:0];
    return c;
  endfunction

  // random command; some speeds sit around the deadband or at zero, some headings near an axis
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    c.speed    = SPEED_W'($urandom);
    c.heading  = HEADING_W'($urandom);
    c.rotation = ROT_W'($urandom);
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      c.speed = SPEED_W'($urandom_range(0, 2 * deadband_reg + 2));
      if ($urandom_range(0, 1) == 1) c.speed = -c.speed;
    end else if (pick == 1) begin
      c.heading = 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 8) - 4);
    end else if (pick == 2) begin
      c.speed    = '0;
    end
    return c;
  endfunction

  task automatic drain_pipeline();
    cmd_valid <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk);
  endtask

  // both registers are written back to back once nothing is in flight
  task automatic set_config(input logic [CFG_DATA_W-1:0] db_word,
                            input logic [CFG_DATA_W-1:0] gain_word);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEADBAND;
    cfg_data  <= db_word;
    do @(posedge clk); while (!cfg_ready);
    deadband_reg = db_word[DB_W-1:0];
    cfg_index <= REG_RPM_GAIN;
    cfg_data  <= gain_word;
    do @(posedge clk); while (!cfg_ready);
    gain_reg  = gain_word;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_cmd(rand_cmd());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: field extremes, axes, quadrant edges, deadband edge
  task automatic test_directed();
    // all zero, then full speed both ways with rotation extremes
    send_cmd(mk_cmd(0, 0, 0));
    send_cmd(mk_cmd(16383, 0, 7));
    send_cmd(mk_cmd(-16384, 0, -8));
    send_cmd(mk_cmd(16383, 16384, 0));
    send_cmd(mk_cmd(-16384, 32768, 0));
    send_cmd(mk_cmd(16383, 49152, -8));
    send_cmd(mk_cmd(16383, 65535, 7));
    send_cmd(mk_cmd(-16384, 8192, 7));
    send_cmd(mk_cmd(16383, 24576, -8));
    // either side of each fold of the angle
    send_cmd(mk_cmd(10000, 16383, 0));
    send_cmd(mk_cmd(10000, 16384, 0));
    send_cmd(mk_cmd(10000, 49151, 0));
    send_cmd(mk_cmd(10000, 49152, 0));
    send_cmd(mk_cmd(10000, 32767, 3));
    // component right at the deadband: 205 * 32767 still falls below it
    send_cmd(mk_cmd(204, 0, 0));
    send_cmd(mk_cmd(205, 0, 0));
    send_cmd(mk_cmd(206, 0, 0));
    send_cmd(mk_cmd(-205, 0, 0));
    send_cmd(mk_cmd(-206, 0, 0));
    send_cmd(mk_cmd(206, 16384, -1));
    send_cmd(mk_cmd(300, 8192, 0));
    // rotation alone
    send_cmd(mk_cmd(0, 12345, -8));
    send_cmd(mk_cmd(0, 0, 7));
  endtask

  // register extremes, zero gain and data bits above the deadband width
  task automatic test_register_extremes();
    set_config(16'h0000, 16'hFFFF);
    send_random(40);
    set_config(16'h0FFF, 16'h0000);
    send_random(40);
    set_config(16'hFFFF, 16'h0001);
    send_random(40);
    set_config(16'hF0CD, 16'h8000);
    send_random(40);
    set_config(16'h0001, 16'd12223);
    send_random(40);
  endtask

  // bulk random commands, a fresh random setting per phase
  task automatic test_random_phases();
    for (int p = 0; p < 9; p++) begin
      set_config(16'($urandom), 16'($urandom));
      send_random(100);
    end
  endtask

  // wheel side holds off long enough that the pipeline fills and stalls commands
  task automatic test_output_holdoff();
    set_config(16'd205, 16'd12223);
    hold_req++;
    send_random(80);
  endtask

  // closing stretch with no idling on either side
  task automatic test_streaming();
    drain_pipeline();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(150);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_random_phases();
    test_output_holdoff();
    test_streaming();

    drain_pipeline();
    // let any stray beat surface past the pipeline depth
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_wheels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
